FILE: design/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, codes and helpers for the keyed residency table.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int RES_W        = 2;
	localparam int REQ_W        = 3;
	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 7;

	// Request codes; unused codes behave as a lookup
	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

	// Response status codes
	localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EXISTS   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_MISSING  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_STEP = 3'd3;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

	localparam logic [RES_W-1:0] RES_UNLOADED = 2'd0;

	typedef enum logic [1:0] {
		CTRL_IDLE,
		CTRL_SCAN,
		CTRL_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_sts_t;

	// Residency may hold or advance one step around the cycle
	function automatic logic step_allowed(input logic [RES_W-1:0] cur,
			input logic [RES_W-1:0] nxt);
		logic [RES_W-1:0] adv;
		adv = cur + RES_W'(1);
		return (nxt == cur) || (nxt == adv);
	endfunction

endpackage

FILE: design/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// Request sequencer: accept, scan the table, commit into the response register.
// ----------------------------------------------------------------------------
module krt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output krt_pkg::dp_cmd_t  cmd,
	input  krt_pkg::dp_sts_t  sts
);

	krt_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::CTRL_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		unique case (state_q)
			krt_pkg::CTRL_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_nxt = krt_pkg::CTRL_SCAN;
				end
			end
			krt_pkg::CTRL_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = krt_pkg::CTRL_COMMIT;
				end
			end
			krt_pkg::CTRL_COMMIT: begin
				// hold until the response register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = krt_pkg::CTRL_IDLE;
				end
			end
			default: begin
				state_nxt = krt_pkg::CTRL_IDLE;
			end
		endcase
	end

endmodule

FILE: design/krt_datapath.sv
// ----------------------------------------------------------------------------
// krt_datapath
// Key/residency store, valid bits, sequential slot scan and response register.
// ----------------------------------------------------------------------------
module krt_datapath #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  krt_pkg::dp_cmd_t                     cmd,
	output krt_pkg::dp_sts_t                     sts,
	input  logic [krt_pkg::REQ_W-1:0]            req_type,
	input  logic signed [krt_pkg::KEY_W-1:0]     chunk_x,
	input  logic signed [krt_pkg::KEY_W-1:0]     chunk_y,
	input  logic signed [krt_pkg::KEY_W-1:0]     chunk_z,
	input  logic [krt_pkg::RES_W-1:0]            new_state,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [krt_pkg::STATUS_W-1:0]         status,
	output logic                                 found,
	output logic [krt_pkg::RES_W-1:0]            residency,
	output logic [krt_pkg::COUNT_W-1:0]          entry_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KW    = krt_pkg::KEY_W;
	localparam int RW    = krt_pkg::RES_W;
	localparam int ENT_W = 3 * KW + RW;

	// request registers
	logic [krt_pkg::REQ_W-1:0] req_q;
	logic [KW-1:0]             kx_q, ky_q, kz_q;
	logic [RW-1:0]             want_q;

	// scan state
	logic [CNT_W-1:0] scan_q;
	logic [IDX_W-1:0] idx_s1;
	logic             rd_vld_s1;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [RW-1:0]    hit_res_q;

	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    cnt_q;

	// response register
	logic                          rsp_vld_q;
	logic [krt_pkg::STATUS_W-1:0]  status_q;
	logic                          found_q;
	logic [RW-1:0]                 res_q;

	logic             is_clear, scan_end, rd_issue, entry_hit;
	logic [ENT_W-1:0] rdata, wdata;
	logic [KW-1:0]    rd_x, rd_y, rd_z;
	logic [RW-1:0]    rd_res;
	logic             we;
	logic [IDX_W-1:0] waddr;

	// commit decisions
	logic [krt_pkg::STATUS_W-1:0] c_status;
	logic                         c_found;
	logic [RW-1:0]                c_res;
	logic                         c_set, c_clr, c_clr_all;

	assign is_clear = (req_q == krt_pkg::REQ_CLEAR);
	assign scan_end = (scan_q == CNT_W'(CAPACITY));
	assign rd_issue = cmd.scan && !is_clear && !hit_q && !scan_end;

	assign rd_x   = rdata[ENT_W-1 -: KW];
	assign rd_y   = rdata[ENT_W-KW-1 -: KW];
	assign rd_z   = rdata[ENT_W-2*KW-1 -: KW];
	assign rd_res = rdata[RW-1:0];

	assign entry_hit = valid_q[idx_s1] && (rd_x == kx_q) && (rd_y == ky_q) && (rd_z == kz_q);

	assign sts.scan_done = !rd_vld_s1 && (is_clear || hit_q || scan_end);
	assign sts.out_free  = !rsp_vld_q || !rsp_stall;

	krt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_issue),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= req_type;
			kx_q   <= chunk_x;
			ky_q   <= chunk_y;
			kz_q   <= chunk_z;
			want_q <= new_state;
		end
		if (rd_issue) begin
			idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (rd_vld_s1 && entry_hit && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_res_q <= rd_res;
		end
		if (rd_vld_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			status_q <= c_status;
			found_q  <= c_found;
			res_q    <= c_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.start) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (rd_vld_s1 && entry_hit) begin
				hit_q <= 1'b1;
			end
			if (rd_vld_s1 && !valid_q[idx_s1]) begin
				free_q <= 1'b1;
			end
		end
	end

	always_comb begin
		c_status  = krt_pkg::STS_OK;
		c_found   = hit_q;
		c_res     = krt_pkg::RES_UNLOADED;
		c_set     = 1'b0;
		c_clr     = 1'b0;
		c_clr_all = 1'b0;
		we        = 1'b0;
		waddr     = hit_idx_q;
		wdata     = {kx_q, ky_q, kz_q, want_q};
		unique case (req_q)
			krt_pkg::REQ_CREATE: begin
				if (hit_q) begin
					c_status = krt_pkg::STS_EXISTS;
					c_res    = hit_res_q;
				end else if (!free_q) begin
					c_status = krt_pkg::STS_FULL;
				end else begin
					c_set = 1'b1;
					we    = 1'b1;
					waddr = free_idx_q;
					wdata = {kx_q, ky_q, kz_q, krt_pkg::RES_UNLOADED};
				end
			end
			krt_pkg::REQ_REMOVE: begin
				if (hit_q) begin
					c_clr = 1'b1;
				end else begin
					c_status = krt_pkg::STS_MISSING;
				end
			end
			krt_pkg::REQ_SET: begin
				if (!hit_q) begin
					c_status = krt_pkg::STS_MISSING;
				end else if (!krt_pkg::step_allowed(hit_res_q, want_q)) begin
					c_status = krt_pkg::STS_BAD_STEP;
					c_res    = hit_res_q;
				end else begin
					we    = 1'b1;
					c_res = want_q;
				end
			end
			krt_pkg::REQ_CLEAR: begin
				c_clr_all = 1'b1;
				c_found   = 1'b0;
			end
			default: begin
				if (hit_q) begin
					c_res = hit_res_q;
				end else begin
					c_status = krt_pkg::STS_MISSING;
				end
			end
		endcase
		we = we && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cnt_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (c_clr_all) begin
					valid_q <= '0;
					cnt_q   <= '0;
				end else if (c_set) begin
					valid_q[free_idx_q] <= 1'b1;
					cnt_q               <= cnt_q + CNT_W'(1);
				end else if (c_clr) begin
					valid_q[hit_idx_q] <= 1'b0;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end
			if (cmd.commit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && !rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// count is read straight from the counter, so it shows the value after the commit; it only changes at commit
	assign rsp_valid   = rsp_vld_q;
	assign status      = status_q;
	assign found       = found_q;
	assign residency   = res_q;
	assign entry_count = krt_pkg::COUNT_W'(cnt_q);

endmodule

FILE: design/keyed_residency_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_residency_table_unit
// Bounded table of keyed entries, each holding a four-state residency value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries req_type, the three-part
//   key chunk_x/y/z and new_state. Response channel (rsp_valid/rsp_stall)
//   returns status, found, residency and entry_count, one per request.
//   Keys and residencies live in a single RAM that is read one slot per
//   cycle; valid bits and the entry count are flip-flops.
// Sequencing:
//   A request scans slots from 0 until its key matches or the table ends;
//   clear all reads no slots. The result is written into the response
//   register at commit, once that register is free.
//   One request is in work at a time; the next is taken after it commits.
// Reset and stall:
//   After reset the table is empty and ready at once. A stalled response
//   holds in the output register; the next request is still accepted and
//   scanned, and waits to commit until the register frees.
// ----------------------------------------------------------------------------
module keyed_residency_table_unit #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [krt_pkg::REQ_W-1:0]         req_type,
	input  logic signed [krt_pkg::KEY_W-1:0]  chunk_x,
	input  logic signed [krt_pkg::KEY_W-1:0]  chunk_y,
	input  logic signed [krt_pkg::KEY_W-1:0]  chunk_z,
	input  logic [krt_pkg::RES_W-1:0]         new_state,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [krt_pkg::STATUS_W-1:0]      status,
	output logic                              found,
	output logic [krt_pkg::RES_W-1:0]         residency,
	output logic [krt_pkg::COUNT_W-1:0]       entry_count
);

	krt_pkg::dp_cmd_t cmd;
	krt_pkg::dp_sts_t sts;

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	krt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.chunk_x     (chunk_x),
		.chunk_y     (chunk_y),
		.chunk_z     (chunk_z),
		.new_state   (new_state),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found       (found),
		.residency   (residency),
		.entry_count (entry_count)
	);

endmodule

FILE: design/krt_checker.sv
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks for the keyed residency table, bound to the top level.
// ----------------------------------------------------------------------------
module krt_checker #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [krt_pkg::STATUS_W-1:0]      status,
	input logic                              found,
	input logic [krt_pkg::RES_W-1:0]         residency,
	input logic [krt_pkg::COUNT_W-1:0]       entry_count
);

	// a stalled response transaction holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found)
			&& $stable(residency) && $stable(entry_count))
		else $error("response changed while stalled");

	// one request in work: busy right after a request transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous still scanning");

	// absent key reports unloaded residency
	a_absent_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> residency == krt_pkg::RES_UNLOADED)
		else $error("residency reported for absent key");

	// duplicate and missing statuses agree with the found flag
	a_found_sts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status != krt_pkg::STS_EXISTS || found)
			&& (status != krt_pkg::STS_MISSING || !found))
		else $error("status disagrees with found flag");

	// a full table reports capacity as its count
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == krt_pkg::STS_FULL
			|-> entry_count == krt_pkg::COUNT_W'(CAPACITY) && !found)
		else $error("table full reported below capacity");

endmodule

bind keyed_residency_table_unit krt_checker #(
	.CAPACITY (CAPACITY)
) u_krt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.found       (found),
	.residency   (residency),
	.entry_count (entry_count)
);

FILE: test/tb_keyed_residency_table_unit.sv
// ----------------------------------------------------------------------------
// tb_keyed_residency_table_unit
// Self-checking bench for the keyed residency table. A shadow table in the
// bench predicts status, found flag, residency and entry count of every
// accepted request; a checker compares each response transaction in order.
// Directed cases, a residency walk, a full-table run and random traffic over
// a small key pool drive the block with random gaps and response stalls.
// ----------------------------------------------------------------------------
module tb_keyed_residency_table_unit;
	import krt_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = CAP + 8;

	localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_CLEAR + 3'd1;
	localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = '1;

	localparam logic [RES_W-1:0] RES_LOADING   = 2'd1;
	localparam logic [RES_W-1:0] RES_RESIDENT  = 2'd2;
	localparam logic [RES_W-1:0] RES_UNLOADING = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] x;
		logic [KEY_W-1:0] y;
		logic [KEY_W-1:0] z;
	} chunk_key_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [RES_W-1:0]    residency;
		logic [COUNT_W-1:0]  count;
	} table_rsp_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic [REQ_W-1:0]          req_type = REQ_LOOKUP;
	logic signed [KEY_W-1:0]   chunk_x = '0;
	logic signed [KEY_W-1:0]   chunk_y = '0;
	logic signed [KEY_W-1:0]   chunk_z = '0;
	logic [RES_W-1:0]          new_state = RES_UNLOADED;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	logic [STATUS_W-1:0]       status;
	logic                      found;
	logic [RES_W-1:0]          residency;
	logic [COUNT_W-1:0]        entry_count;

	// shadow table
	bit                tbl_valid[CAP];
	chunk_key_t        tbl_key[CAP];
	logic [RES_W-1:0]  tbl_res[CAP];
	int                tbl_count;

	table_rsp_t        expected_rsp_q[$];
	int                mismatch_count;
	int                idle_cycles;
	bit                req_quiet;
	bit                rsp_quiet;
	int                stall_left;

	keyed_residency_table_unit #(
		.CAPACITY(CAP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.chunk_x    (chunk_x),
		.chunk_y    (chunk_y),
		.chunk_z    (chunk_z),
		.new_state  (new_state),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.found      (found),
		.residency  (residency),
		.entry_count(entry_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------- shadow table ----------------

	function automatic int find_slot(input chunk_key_t key);
		for (int i = 0; i < CAP; i++)
			if (tbl_valid[i] && tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic [RES_W-1:0] current_residency(input chunk_key_t key);
		int slot;
		slot = find_slot(key);
		return (slot >= 0) ? tbl_res[slot] : RES_UNLOADED;
	endfunction

	function automatic bit advance_ok(input logic [RES_W-1:0] cur, input logic [RES_W-1:0] nxt);
		logic [RES_W-1:0] ahead;
		ahead = cur + RES_LOADING;
		return (nxt == cur) || (nxt == ahead);
	endfunction

	function automatic table_rsp_t apply_request(input logic [REQ_W-1:0] kind,
			input chunk_key_t key, input logic [RES_W-1:0] want);
		table_rsp_t rsp;
		int hit;
		int free;
		hit = find_slot(key);
		rsp.status = STS_OK;
		rsp.found = (hit >= 0);
		rsp.residency = RES_UNLOADED;
		case (kind)
			REQ_CREATE: begin
				if (hit >= 0) begin
					rsp.status = STS_EXISTS;
					rsp.residency = tbl_res[hit];
				end else begin
					free = -1;
					for (int i = CAP - 1; i >= 0; i--)
						if (!tbl_valid[i])
							free = i;
					if (free < 0) begin
						rsp.status = STS_FULL;
					end else begin
						tbl_valid[free] = 1'b1;
						tbl_key[free] = key;
						tbl_res[free] = RES_UNLOADED;
						tbl_count++;
					end
				end
			end
			REQ_REMOVE: begin
				if (hit >= 0) begin
					tbl_valid[hit] = 1'b0;
					tbl_count--;
				end else begin
					rsp.status = STS_MISSING;
				end
			end
			REQ_SET: begin
				if (hit < 0) begin
					rsp.status = STS_MISSING;
				end else if (!advance_ok(tbl_res[hit], want)) begin
					rsp.status = STS_BAD_STEP;
					rsp.residency = tbl_res[hit];
				end else begin
					tbl_res[hit] = want;
					rsp.residency = want;
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < CAP; i++)
					tbl_valid[i] = 1'b0;
				tbl_count = 0;
				rsp.found = 1'b0;
			end
			default: begin
				if (hit >= 0)
					rsp.residency = tbl_res[hit];
				else
					rsp.status = STS_MISSING;
			end
		endcase
		rsp.count = COUNT_W'(tbl_count);
		return rsp;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [KEY_W-1:0] random_coord();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(KEY_W-1){1'b0}}};
			1: return {1'b0, {(KEY_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic chunk_key_t random_key();
		chunk_key_t key;
		key.x = random_coord();
		key.y = random_coord();
		key.z = random_coord();
		return key;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (req_quiet || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Entered and left at a falling edge; valid stays high into the next call.
	task automatic send_request(input logic [REQ_W-1:0] kind, input chunk_key_t key,
			input logic [RES_W-1:0] want);
		int gap;
		gap = pick_gap();
		if ($urandom_range(0, 39) == 0)
			req_quiet = !req_quiet;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= kind;
		chunk_x <= key.x;
		chunk_y <= key.y;
		chunk_z <= key.z;
		new_state <= want;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsp_q.push_back(apply_request(kind, key, want));
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_rsp_q.size() != 0);
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		chunk_key_t ka;
		chunk_key_t kb;
		chunk_key_t kc;
		chunk_key_t kd;
		ka = '{x: {1'b1, {(KEY_W-1){1'b0}}}, y: {1'b0, {(KEY_W-1){1'b1}}}, z: '0};
		kb = '{x: ka.x, y: ka.y, z: '1};
		kc = '0;
		kd = '1;
		// operations on an empty table, then a duplicate create and a second key
		send_request(REQ_LOOKUP, ka, RES_UNLOADED);
		send_request(REQ_REMOVE, ka, RES_UNLOADED);
		send_request(REQ_SET, ka, RES_LOADING);
		send_request(REQ_CREATE, ka, RES_UNLOADING);
		send_request(REQ_CREATE, ka, RES_UNLOADED);
		send_request(REQ_CREATE, kb, RES_UNLOADED);
		// skip a step, hold, then go around the whole cycle
		send_request(REQ_SET, ka, RES_RESIDENT);
		send_request(REQ_SET, ka, RES_UNLOADED);
		send_request(REQ_SET, ka, RES_LOADING);
		send_request(REQ_SET, ka, RES_UNLOADING);
		send_request(REQ_SET, ka, RES_RESIDENT);
		send_request(REQ_SET, ka, RES_UNLOADING);
		send_request(REQ_CREATE, ka, RES_UNLOADED);
		send_request(REQ_SET, ka, RES_UNLOADED);
		send_request(REQ_LOOKUP, kb, RES_UNLOADED);
		for (int t = REQ_UNUSED_FIRST; t <= REQ_UNUSED_LAST; t++)
			send_request(REQ_W'(t), (t == REQ_UNUSED_LAST) ? kc : ka, RES_UNLOADING);
		send_request(REQ_CREATE, kc, RES_UNLOADED);
		send_request(REQ_CREATE, kd, RES_UNLOADED);
		send_request(REQ_REMOVE, kb, RES_UNLOADED);
		send_request(REQ_LOOKUP, kb, RES_UNLOADED);
		send_request(REQ_CLEAR, kd, RES_UNLOADING);
		send_request(REQ_LOOKUP, ka, RES_UNLOADED);
		send_request(REQ_CREATE, ka, RES_UNLOADED);
	endtask

	task automatic test_residency_walk();
		chunk_key_t key;
		logic [RES_W-1:0] cur;
		key = random_key();
		send_request(REQ_CREATE, key, RES_UNLOADED);
		for (int s = 0; s < 8; s++) begin
			cur = current_residency(key);
			send_request(REQ_SET, key, cur + RES_RESIDENT);
			send_request(REQ_SET, key, cur + RES_UNLOADING);
			send_request(REQ_SET, key, cur + RES_LOADING);
		end
		send_request(REQ_LOOKUP, key, RES_UNLOADED);
		send_request(REQ_REMOVE, key, RES_UNLOADED);
		send_request(REQ_SET, key, RES_LOADING);
	endtask

	task automatic test_full_table();
		chunk_key_t keys[CAP];
		chunk_key_t spare;
		send_request(REQ_CLEAR, random_key(), RES_UNLOADED);
		for (int i = 0; i < CAP; i++) begin
			keys[i] = '{x: $urandom, y: KEY_W'(i), z: $urandom};
			send_request(REQ_CREATE, keys[i], RES_UNLOADED);
		end
		spare = '{x: $urandom, y: KEY_W'(CAP), z: $urandom};
		send_request(REQ_CREATE, spare, RES_UNLOADED);
		send_request(REQ_CREATE, keys[CAP-1], RES_UNLOADED);
		send_request(REQ_SET, keys[CAP-1], RES_LOADING);
		send_request(REQ_LOOKUP, keys[CAP-1], RES_UNLOADED);
		send_request(REQ_LOOKUP, spare, RES_UNLOADED);
		// free a middle slot, refill it, then overflow again
		send_request(REQ_REMOVE, keys[CAP/2], RES_UNLOADED);
		send_request(REQ_CREATE, spare, RES_UNLOADED);
		send_request(REQ_SET, spare, RES_LOADING);
		send_request(REQ_CREATE, keys[CAP/2], RES_UNLOADED);
		send_request(REQ_LOOKUP, spare, RES_UNLOADED);
		wait_results_drained();
		send_request(REQ_CLEAR, spare, RES_UNLOADED);
	endtask

	task automatic test_random_traffic(input int n_items);
		chunk_key_t pool[8];
		chunk_key_t key;
		logic [REQ_W-1:0] kind;
		logic [RES_W-1:0] want;
		int roll;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				foreach (pool[j])
					pool[j] = random_key();
				// near neighbors: same x and y, different z
				pool[1].x = pool[0].x;
				pool[1].y = pool[0].y;
			end
			key = ($urandom_range(0, 9) == 0) ? random_key() : pool[$urandom_range(0, 7)];
			roll = $urandom_range(0, 99);
			if (roll < 20)
				kind = REQ_CREATE;
			else if (roll < 30)
				kind = REQ_REMOVE;
			else if (roll < 65)
				kind = REQ_SET;
			else if (roll < 90)
				kind = REQ_LOOKUP;
			else if (roll < 97)
				kind = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
			else
				kind = REQ_CLEAR;
			want = RES_W'($urandom_range(0, 3));
			if (kind == REQ_SET && $urandom_range(0, 3) != 0)
				want = current_residency(key) + RES_W'($urandom_range(0, 1));
			send_request(kind, key, want);
		end
	endtask

	// ---------------- response side ----------------

	always @(negedge clk) begin
		int roll;
		if ($urandom_range(0, 63) == 0)
			rsp_quiet = !rsp_quiet;
		if (stall_left == 0 && !rsp_quiet) begin
			roll = $urandom_range(0, 99);
			if (roll >= 95)
				stall_left = $urandom_range(10, 30);
			else if (roll >= 70)
				stall_left = $urandom_range(1, 3);
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		table_rsp_t exp_rsp;
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				if (status !== exp_rsp.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, exp_rsp.status));
				if (found !== exp_rsp.found)
					report_mismatch($sformatf("found %0d, expected %0d",
						found, exp_rsp.found));
				if (residency !== exp_rsp.residency)
					report_mismatch($sformatf("residency %0d, expected %0d",
						residency, exp_rsp.residency));
				if (entry_count !== exp_rsp.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, exp_rsp.count));
			end
		end
	end

	// end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_residency_walk();
		test_full_table();
		test_random_traffic(320);
		wait_results_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: keyed_residency_table_unit.f
design/krt_pkg.sv
design/krt_ram.sv
design/krt_ctrl.sv
design/krt_datapath.sv
design/keyed_residency_table_unit.sv
design/krt_checker.sv
test/tb_keyed_residency_table_unit.sv
